>>> design/kscq_pkg.sv
// Package for the keyboard scancode queue.
// Holds the item payload types, the function codes, the controller state type
// and the fixed byte constants. It depends on nothing.
package kscq_pkg;

    // Function codes carried by an input item.
    typedef enum logic [1:0] {
        FUNC_KEY     = 2'd0,
        FUNC_DATA    = 2'd1,
        FUNC_STATUS  = 2'd2,
        FUNC_ADVANCE = 2'd3
    } func_t;

    typedef struct packed {
        func_t      func;
        logic       extended;
        logic [7:0] scan_code;
        logic       pressed;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pending;
        logic [5:0] queued_count;
        logic [1:0] dropped;
    } out_item_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREFIX,
        S_CODE,
        S_READ,
        S_STATUS,
        S_ADVANCE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic push_prefix;
        logic push_code;
        logic do_read;
        logic do_status;
        logic do_advance;
        logic load_out;
    } cmd_t;

    localparam logic [7:0] PREFIX_BYTE    = 8'hE0;
    localparam logic [7:0] RELEASE_OFFSET = 8'd128;
    localparam logic [7:0] STATUS_BYTE    = 8'h1D;

endpackage

>>> design/kscq_ctrl.sv
// Controller state machine of the keyboard scancode queue.
// Sequences the steps of each item and drives the handshakes.
// Depends on kscq_pkg.
module kscq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  kscq_pkg::in_item_t in_item,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output kscq_pkg::cmd_t    cmd
);
    import kscq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   in_take;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_take   = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_item.func)
                        FUNC_KEY:     state_next = in_item.extended ? S_PREFIX : S_CODE;
                        FUNC_DATA:    state_next = S_READ;
                        FUNC_STATUS:  state_next = S_STATUS;
                        FUNC_ADVANCE: state_next = S_ADVANCE;
                    endcase
                end
            end
            S_PREFIX:
            begin
                state_next = S_CODE;
            end
            S_CODE, S_READ, S_STATUS, S_ADVANCE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands. The last step of an item waits until the output register is free,
    // so that its effects and its result are committed in the same cycle.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = in_take;
            end
            S_PREFIX:
            begin
                cmd.push_prefix = 1'b1;
            end
            S_CODE:
            begin
                cmd.push_code = out_free;
                cmd.load_out  = out_free;
            end
            S_READ:
            begin
                cmd.do_read  = out_free;
                cmd.load_out = out_free;
            end
            S_STATUS:
            begin
                cmd.do_status = out_free;
                cmd.load_out  = out_free;
            end
            S_ADVANCE:
            begin
                cmd.do_advance = out_free;
                cmd.load_out   = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted item always starts a sequence.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start a sequence");

    // A result is only loaded when the output register can take it.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result loaded over an untaken result");

    // A prefix push is always followed by the scancode step.
    a_prefix_then_code: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREFIX) |=> (state_reg == S_CODE))
        else $error("prefix step not followed by scancode step");

endmodule

>>> design/kscq_dp.sv
// Datapath of the keyboard scancode queue: byte ring, data latch, flags,
// key mode register and the output payload register.
// Depends on kscq_pkg.
module kscq_dp #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  kscq_pkg::cmd_t     cmd,
    input  kscq_pkg::in_item_t in_item,
    input  logic               cfg_we,
    input  logic               cfg_data,
    output kscq_pkg::out_item_t out_item
);
    import kscq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_W  = (CNT_W + 1)'(QUEUE_DEPTH);

    logic [7:0]       ring_mem [QUEUE_DEPTH];
    logic [7:0]       rdata_reg;

    logic [IDX_W-1:0] head_reg,   head_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [7:0]       latch_reg,  latch_next;
    logic             unread_reg, unread_next;
    logic             irq_reg,    irq_next;
    logic             key_mode_reg;
    logic             drop_pre_reg, drop_pre_next;
    logic [7:0]       code_reg;
    logic             pressed_reg;
    out_item_t        out_reg;
    out_item_t        out_next;

    logic             push_en;
    logic [7:0]       push_byte;
    logic             full;
    logic [CNT_W:0]   tail_sum;
    logic [IDX_W-1:0] tail_addr;
    logic [IDX_W-1:0] head_inc;
    logic             wr_en;
    logic             code_drop;
    logic [7:0]       rd_byte;

    assign push_en   = cmd.push_prefix || cmd.push_code;
    assign push_byte = cmd.push_prefix ? PREFIX_BYTE
                     : (pressed_reg ? code_reg : code_reg + RELEASE_OFFSET);
    assign full      = (count_reg == FULL_CNT);
    assign tail_sum  = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign tail_addr = IDX_W'((tail_sum >= DEPTH_W) ? tail_sum - DEPTH_W : tail_sum);
    assign head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign wr_en     = push_en && !full;
    assign code_drop = cmd.push_code && full;

    // Ring and latch update. The head byte comes from the registered memory
    // read, which always tracks the current head; when the ring was empty the
    // pushed byte itself is the head byte.
    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        latch_next    = latch_reg;
        unread_next   = unread_reg;
        irq_next      = irq_reg;
        drop_pre_next = drop_pre_reg;
        if (cmd.load_item)
        begin
            drop_pre_next = 1'b0;
        end
        if (cmd.push_prefix && full)
        begin
            drop_pre_next = 1'b1;
        end
        if (wr_en)
        begin
            if (unread_reg)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                latch_next  = (count_reg == '0) ? push_byte : rdata_reg;
                head_next   = head_inc;
                unread_next = 1'b1;
                irq_next    = 1'b1;
            end
        end
        else if (cmd.do_advance)
        begin
            if ((count_reg != '0) && !unread_reg)
            begin
                latch_next  = rdata_reg;
                head_next   = head_inc;
                count_next  = count_reg - 1'b1;
                unread_next = 1'b1;
                irq_next    = 1'b1;
            end
        end
        else if (cmd.do_read && key_mode_reg)
        begin
            unread_next = 1'b0;
            irq_next    = 1'b0;
        end
    end

    always_comb
    begin
        rd_byte = '0;
        if (cmd.do_read && key_mode_reg)
        begin
            rd_byte = latch_reg;
        end
        else if (cmd.do_status)
        begin
            rd_byte = STATUS_BYTE;
        end
        out_next.read_data    = rd_byte;
        out_next.irq_pending  = irq_next;
        out_next.queued_count = 6'(count_next);
        out_next.dropped      = 2'(drop_pre_reg) + 2'(code_drop);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[tail_addr] <= push_byte;
        end
        rdata_reg <= ring_mem[head_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            latch_reg    <= '0;
            unread_reg   <= 1'b0;
            irq_reg      <= 1'b0;
            key_mode_reg <= 1'b1;
            drop_pre_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            latch_reg    <= latch_next;
            unread_reg   <= unread_next;
            irq_reg      <= irq_next;
            drop_pre_reg <= drop_pre_next;
            if (cfg_we)
            begin
                key_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            code_reg    <= in_item.scan_code;
            pressed_reg <= in_item.pressed;
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_item = out_reg;

    // The fill count never passes the ring depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("ring fill count beyond depth");

    // The interrupt request follows the unread flag exactly.
    a_irq_tracks_unread: assert property (@(posedge clk) disable iff (!rst_n)
        irq_reg == unread_reg)
        else $error("interrupt request and unread flag disagree");

    // A byte only moves into the latch when the latch held nothing unread.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (unread_reg && !(cmd.do_read && key_mode_reg)) |=> unread_reg)
        else $error("unread latch byte lost");

endmodule

>>> design/keyboard_scancode_queue.sv
// Top level of the keyboard scancode queue.
// Instantiates the controller (kscq_ctrl) and the datapath (kscq_dp).
// Depends on kscq_pkg.
//
// Usage: one input channel carries items (in_valid, in_stall, in_item) and one
// output channel carries results (out_valid, out_stall, out_item). A transfer
// happens on a rising edge where valid is high and stall is low. Every item
// produces exactly one result. Key events push an optional 0xE0 prefix and the
// scancode into a byte ring; data-port reads return the data latch while key
// mode is 1 and 0x00 otherwise, status reads return 0x1D, and advance items
// retry the move from the ring into the latch.
// Timing: an item is taken in the idle state; an extended key event then
// passes through the prefix state, whose ring write is a step of its own, and
// every item ends in its final step (scancode push, read, status read or
// advance), which loads the result into the output register. A new item is
// taken while that result still waits.
// If the receiver stalls, the final step of the next item waits until the output
// register is free, so no result is lost or overwritten.
// Reset clears the ring pointers, fill count, latch, flags and output valid, and
// sets key mode to 1. cfg_we and cfg_data write key mode in any cycle.
module keyboard_scancode_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  kscq_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output kscq_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  logic                cfg_data
);
    import kscq_pkg::*;

    // Command bundle from the controller to the datapath.
    cmd_t cmd;

    kscq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    kscq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_item  (in_item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .out_item (out_item)
    );

endmodule
